/* rtl/level_priority_interrupt_controller_unit_assert.svh */
// assertion macros for the level priority interrupt controller
`ifndef LEVEL_PRIORITY_INTERRUPT_CONTROLLER_UNIT_ASSERT_SVH
`define LEVEL_PRIORITY_INTERRUPT_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, quiet while reset is asserted
`define LPIC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lpic assertion failed");

// next-cycle implication, quiet while reset is asserted
`define LPIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lpic assertion failed");

`endif

/* rtl/lpic_pkg.sv */
// types and constants of the level priority interrupt controller
package lpic_pkg;

	localparam int LINE_W     = 32;
	localparam int IDX_W      = 5;
	localparam int CUR_W      = 4;
	localparam int LEVEL_W    = 3;
	localparam int MAX_LEVELS = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam int NUM_LINES_DEF  = 32;
	localparam int NUM_LEVELS_DEF = 7;

	localparam logic [LEVEL_W-1:0] NMI_PRI_RST = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TYPE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NMI_LINE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NMI_PRI     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_1_2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_3_4   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_5_6   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_7     = 3'd6;

	localparam logic MODE_EVENT  = 1'b0;
	localparam logic MODE_REEVAL = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [IDX_W-1:0]   line_index;
		logic               line_active;
		logic [LINE_W-1:0]  enable_mask;
		logic [CUR_W-1:0]   current_level;
	} req_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] request_level;
		logic               request_active;
		logic               bad_line;
		logic [LINE_W-1:0]  pending_bits;
	} rsp_t;

endpackage

/* rtl/lpic_if.sv */
// request, result and configuration channels of the interrupt controller
interface lpic_req_if;
	logic          valid;
	logic          ready;
	lpic_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lpic_rsp_if;
	logic          valid;
	logic          ready;
	lpic_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lpic_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [lpic_pkg::CFG_IDX_W-1:0]      index;
	logic [lpic_pkg::CFG_DATA_W-1:0]     wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

/* rtl/level_priority_interrupt_controller_unit.sv */
// level priority interrupt controller: pending set, gating and level select
//
// channels: req takes one request per handshake (valid and ready both high):
// a line event (mode 0) or a re-evaluation (mode 1) with the enable bits and
// the current processor level. rsp returns exactly one result per request:
// request level, request active, bad line flag and the pending bits.
// cfg writes one of seven registers by index; it is always ready. The user
// must write it only while no request is in flight; it is not enforced.
// path: a request is registered at the input, then one pass of mask
// update, gating and a seven-entry priority select fills the result
// register, which drives rsp.
// throughput: one request per cycle unless rsp stalls; pending set and held
// level update in the edge loading the result, so back-to-back events chain.
// stall: while rsp is held, the result register keeps its value and the
// input register still takes one more request; after that req.ready drops.
// reset: pending set and held level clear, all masks clear and the nmi
// priority returns to 7; both pipeline registers come up empty.
module level_priority_interrupt_controller_unit #(
	parameter int NUM_LINES  = lpic_pkg::NUM_LINES_DEF,
	parameter int NUM_LEVELS = lpic_pkg::NUM_LEVELS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	lpic_cfg_if.sink       cfg,
	lpic_req_if.sink       req,
	lpic_rsp_if.source     rsp
);

	localparam int LINE_W  = lpic_pkg::LINE_W;
	localparam int IDX_W   = lpic_pkg::IDX_W;
	localparam int CUR_W   = lpic_pkg::CUR_W;
	localparam int LEVEL_W = lpic_pkg::LEVEL_W;
	localparam int MAX_LV  = lpic_pkg::MAX_LEVELS;
	localparam logic [LINE_W-1:0] LINE_SPACE = {LINE_W{1'b1}} >> (LINE_W - NUM_LINES);

	logic [LINE_W-1:0]  level_type_q;
	logic [LINE_W-1:0]  nmi_line_q;
	logic [LEVEL_W-1:0] nmi_pri_q;
	logic [LINE_W-1:0]  lvl_mask_q [1:MAX_LV];

	logic [LINE_W-1:0]  pending_q;
	logic [LEVEL_W-1:0] held_level_q;

	logic               req_valid_s1;
	lpic_pkg::req_t     req_s1;
	logic               rsp_valid_q;
	lpic_pkg::rsp_t     rsp_q;

	logic               s1_adv;
	logic               bad;
	logic [LINE_W-1:0]  line_bit;
	logic [LINE_W-1:0]  pend_upd;
	logic [LINE_W-1:0]  pend_eval;
	logic [LINE_W-1:0]  gated;
	logic [CUR_W-1:0]   floor_lv;
	logic [LEVEL_W-1:0] new_level;
	logic [LINE_W-1:0]  next_pending;
	logic [LEVEL_W-1:0] next_level;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_type_q <= '0;
			nmi_line_q   <= '0;
			nmi_pri_q    <= lpic_pkg::NMI_PRI_RST;
			for (int i = 1; i <= MAX_LV; i++) begin
				lvl_mask_q[i] <= '0;
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				lpic_pkg::REG_LEVEL_TYPE: begin
					level_type_q <= cfg.wdata[LINE_W-1:0];
				end
				lpic_pkg::REG_NMI_LINE: begin
					nmi_line_q <= cfg.wdata[LINE_W-1:0];
				end
				lpic_pkg::REG_NMI_PRI: begin
					nmi_pri_q <= cfg.wdata[LEVEL_W-1:0];
				end
				lpic_pkg::REG_LEVEL_1_2: begin
					lvl_mask_q[1] <= cfg.wdata[LINE_W-1:0];
					lvl_mask_q[2] <= cfg.wdata[2*LINE_W-1:LINE_W];
				end
				lpic_pkg::REG_LEVEL_3_4: begin
					lvl_mask_q[3] <= cfg.wdata[LINE_W-1:0];
					lvl_mask_q[4] <= cfg.wdata[2*LINE_W-1:LINE_W];
				end
				lpic_pkg::REG_LEVEL_5_6: begin
					lvl_mask_q[5] <= cfg.wdata[LINE_W-1:0];
					lvl_mask_q[6] <= cfg.wdata[2*LINE_W-1:LINE_W];
				end
				lpic_pkg::REG_LEVEL_7: begin
					lvl_mask_q[7] <= cfg.wdata[LINE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// handshake
	assign s1_adv    = req_valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !req_valid_s1 || s1_adv;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (req.ready) begin
				req_valid_s1 <= req.valid;
			end
			if (s1_adv) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// pending update, gating and level select
	always_comb begin
		line_bit = LINE_W'(1) << req_s1.line_index;
		bad = (req_s1.mode == lpic_pkg::MODE_EVENT) &&
			({1'b0, req_s1.line_index} >= (IDX_W+1)'(NUM_LINES));

		pend_upd = pending_q;
		if (req_s1.line_active) begin
			pend_upd = pending_q | line_bit;
		end else if ((level_type_q & line_bit) != '0) begin
			pend_upd = pending_q & ~line_bit;
		end
		pend_upd = pend_upd & LINE_SPACE;

		pend_eval = (req_s1.mode == lpic_pkg::MODE_EVENT) ? pend_upd : pending_q;
		gated     = pend_eval & (req_s1.enable_mask | nmi_line_q);

		if (nmi_pri_q == '0) begin
			floor_lv = '0;
		end else if (req_s1.current_level >= {1'b0, nmi_pri_q}) begin
			floor_lv = {1'b0, nmi_pri_q - LEVEL_W'(1)};
		end else begin
			floor_lv = req_s1.current_level;
		end

		new_level = '0;
		for (int lv = 1; lv <= MAX_LV; lv++) begin
			if (lv <= NUM_LEVELS && CUR_W'(lv) > floor_lv &&
				(lvl_mask_q[lv] & gated) != '0) begin
				new_level = LEVEL_W'(lv);
			end
		end

		if (bad) begin
			next_pending = pending_q;
			next_level   = held_level_q;
		end else begin
			next_pending = pend_eval;
			next_level   = new_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			held_level_q <= '0;
		end else if (s1_adv) begin
			pending_q    <= next_pending;
			held_level_q <= next_level;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
		if (s1_adv) begin
			rsp_q.request_level  <= next_level;
			rsp_q.request_active <= (next_level != '0);
			rsp_q.bad_line       <= bad;
			rsp_q.pending_bits   <= next_pending;
		end
	end

endmodule

/* rtl/lpic_checker.sv */
// port-level checks of the interrupt controller and their bind
`include "level_priority_interrupt_controller_unit_assert.svh"

module lpic_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input lpic_pkg::rsp_t rsp_data
);

	logic req_acc;
	logic active_ok;

	assign req_acc   = req_valid && req_ready;
	assign active_ok = rsp_data.request_active == (rsp_data.request_level != '0);

	// active flag agrees with the level
	`LPIC_ASSERT_SAME(a_active_level, clk, arst_n, rsp_valid, active_ok)

	// a stalled result holds
	`LPIC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

	// a request taken with the output empty shows up on rsp
	`LPIC_ASSERT_SAME(a_latency, clk, arst_n, req_acc && !rsp_valid, ##2 rsp_valid)

	// no result without a request
	`LPIC_ASSERT_NEXT(a_no_phantom, clk, arst_n, !rsp_valid && !req_acc && !$past(req_acc), !rsp_valid)

endmodule

bind level_priority_interrupt_controller_unit lpic_checker u_lpic_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

/* bench/lpic_outcome_monitor.sv */
// interrupt controller monitor: predicts each result from accepted requests and compares
`timescale 1ns / 100ps

module lpic_outcome_monitor (
	input  logic clk,
	input  logic arst_n,
	lpic_cfg_if  cfg,
	lpic_req_if  req,
	lpic_rsp_if  rsp,
	output int   fail_count,
	output int   outstanding
);

	localparam int REPORT_LIMIT = 10;
	localparam int LINE_W       = lpic_pkg::LINE_W;
	localparam int LEVEL_W      = lpic_pkg::LEVEL_W;
	localparam int CUR_W        = lpic_pkg::CUR_W;
	localparam int MAX_LEVELS   = lpic_pkg::MAX_LEVELS;
	localparam int NUM_LINES    = lpic_pkg::NUM_LINES_DEF;

	logic [LINE_W-1:0]  level_type;
	logic [LINE_W-1:0]  nmi_lines;
	logic [LEVEL_W-1:0] nmi_pri;
	logic [LINE_W-1:0]  level_lines [1:MAX_LEVELS];
	logic [LINE_W-1:0]  pending;
	logic [LEVEL_W-1:0] held;

	lpic_pkg::rsp_t irq_outcomes[$];
	lpic_pkg::rsp_t predicted;
	lpic_pkg::rsp_t observed;

	function automatic logic [LEVEL_W-1:0] top_level(logic [LINE_W-1:0] gated,
			logic [CUR_W-1:0] cur);
		logic [CUR_W-1:0] floor_lvl;
		floor_lvl = cur;
		if (nmi_pri == '0) begin
			floor_lvl = '0;
		end else if (cur >= {1'b0, nmi_pri}) begin
			floor_lvl = {1'b0, nmi_pri - LEVEL_W'(1)};
		end
		for (int lv = MAX_LEVELS; lv >= 1; lv--) begin
			if (lv > int'(floor_lvl) && (level_lines[lv] & gated) != '0) begin
				return LEVEL_W'(lv);
			end
		end
		return '0;
	endfunction

	function automatic lpic_pkg::rsp_t predict_outcome(lpic_pkg::req_t r);
		lpic_pkg::rsp_t o;
		logic [LINE_W-1:0] bit_sel;
		o.bad_line = 1'b0;
		o.pending_bits = pending;
		o.request_level = held;
		if (r.mode == lpic_pkg::MODE_EVENT && int'(r.line_index) >= NUM_LINES) begin
			o.bad_line = 1'b1;
		end else begin
			if (r.mode == lpic_pkg::MODE_EVENT) begin
				bit_sel = LINE_W'(1) << r.line_index;
				if (r.line_active) begin
					o.pending_bits = pending | bit_sel;
				end else if ((level_type & bit_sel) != '0) begin
					o.pending_bits = pending & ~bit_sel;
				end
			end
			o.request_level = top_level(o.pending_bits & (r.enable_mask | nmi_lines),
				r.current_level);
		end
		o.request_active = (o.request_level != '0);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_type = '0;
			nmi_lines = '0;
			nmi_pri = lpic_pkg::NMI_PRI_RST;
			for (int lv = 1; lv <= MAX_LEVELS; lv++) begin
				level_lines[lv] = '0;
			end
			pending = '0;
			held = '0;
			irq_outcomes.delete();
			fail_count = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					lpic_pkg::REG_LEVEL_TYPE: level_type = cfg.wdata[LINE_W-1:0];
					lpic_pkg::REG_NMI_LINE:   nmi_lines = cfg.wdata[LINE_W-1:0];
					lpic_pkg::REG_NMI_PRI:    nmi_pri = cfg.wdata[LEVEL_W-1:0];
					lpic_pkg::REG_LEVEL_1_2: begin
						level_lines[1] = cfg.wdata[31:0];
						level_lines[2] = cfg.wdata[63:32];
					end
					lpic_pkg::REG_LEVEL_3_4: begin
						level_lines[3] = cfg.wdata[31:0];
						level_lines[4] = cfg.wdata[63:32];
					end
					lpic_pkg::REG_LEVEL_5_6: begin
						level_lines[5] = cfg.wdata[31:0];
						level_lines[6] = cfg.wdata[63:32];
					end
					lpic_pkg::REG_LEVEL_7:    level_lines[7] = cfg.wdata[31:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				predicted = predict_outcome(req.data);
				pending = predicted.pending_bits;
				held = predicted.request_level;
				irq_outcomes.push_back(predicted);
			end
			if (rsp.valid && rsp.ready) begin
				observed = rsp.data;
				if (irq_outcomes.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT) begin
						$display("%0t: result with no request waiting: lvl %0d act %0b bad %0b pend %h",
							$realtime, observed.request_level, observed.request_active,
							observed.bad_line, observed.pending_bits);
					end
				end else begin
					predicted = irq_outcomes.pop_front();
					if (observed.request_level !== predicted.request_level ||
							observed.request_active !== predicted.request_active ||
							observed.bad_line !== predicted.bad_line ||
							observed.pending_bits !== predicted.pending_bits) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT) begin
							$display("%0t: wrong result: want lvl %0d act %0b bad %0b pend %h",
								$realtime, predicted.request_level, predicted.request_active,
								predicted.bad_line, predicted.pending_bits);
							$display("%0t:                got lvl %0d act %0b bad %0b pend %h",
								$realtime, observed.request_level, observed.request_active,
								observed.bad_line, observed.pending_bits);
						end
					end
				end
			end
		end
		outstanding = irq_outcomes.size();
	end

endmodule

/* bench/level_priority_interrupt_controller_unit_test.sv */
// testbench top for the interrupt controller: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module level_priority_interrupt_controller_unit_test;

	localparam int HOLD_CYCLES     = 40;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int BLOCKS          = 6;
	localparam int ITEMS_PER_BLOCK = 240;
	localparam int IDX_W           = lpic_pkg::IDX_W;
	localparam int LINE_W          = lpic_pkg::LINE_W;
	localparam int CUR_W           = lpic_pkg::CUR_W;
	localparam int CFG_IDX_W       = lpic_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W      = lpic_pkg::CFG_DATA_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_starts = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int fail_count;
	int outstanding;

	lpic_cfg_if cfg_if ();
	lpic_req_if req_if ();
	lpic_rsp_if rsp_if ();

	level_priority_interrupt_controller_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	lpic_outcome_monitor u_outcomes (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_if),
		.req         (req_if),
		.rsp         (rsp_if),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: random stalls plus a single long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_starts) begin
			hold_seen <= hold_starts;
			hold_left <= HOLD_CYCLES;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	function automatic lpic_pkg::req_t make_req(logic mode, logic [IDX_W-1:0] idx, logic act,
			logic [LINE_W-1:0] en, logic [CUR_W-1:0] cur);
		lpic_pkg::req_t r;
		r.mode = mode;
		r.line_index = idx;
		r.line_active = act;
		r.enable_mask = en;
		r.current_level = cur;
		return r;
	endfunction

	function automatic logic [LINE_W-1:0] sparse_lines();
		return $urandom & $urandom;
	endfunction

	function automatic lpic_pkg::req_t random_req();
		logic [LINE_W-1:0] en;
		case ($urandom_range(0, 7))
			0: en = '0;
			1: en = '1;
			default: en = $urandom;
		endcase
		return make_req(($urandom_range(0, 99) < 15) ? lpic_pkg::MODE_REEVAL : lpic_pkg::MODE_EVENT,
			IDX_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), en,
			CUR_W'($urandom_range(0, 15)));
	endfunction

	task automatic offer(lpic_pkg::req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= r;
		do @(posedge clk); while (!req_if.ready);
	endtask

	// no request goes out until every result is back
	task automatic idle_until_drained();
		req_if.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.wdata <= value;
		do @(posedge clk); while (!cfg_if.ready);
	endtask

	task automatic program_controller(input logic [31:0] lvl_type, input logic [31:0] nmi_lines,
			input logic [2:0] nmi_pri, input logic [63:0] l12, input logic [63:0] l34,
			input logic [63:0] l56, input logic [31:0] l7);
		write_reg(lpic_pkg::REG_LEVEL_TYPE, {32'h0, lvl_type});
		write_reg(lpic_pkg::REG_NMI_LINE, {32'h0, nmi_lines});
		write_reg(lpic_pkg::REG_NMI_PRI, {61'h0, nmi_pri});
		write_reg(lpic_pkg::REG_LEVEL_1_2, l12);
		write_reg(lpic_pkg::REG_LEVEL_3_4, l34);
		write_reg(lpic_pkg::REG_LEVEL_5_6, l56);
		write_reg(lpic_pkg::REG_LEVEL_7, {32'h0, l7});
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		cfg_if.valid <= 1'b0;
		cfg_if.index <= lpic_pkg::REG_LEVEL_TYPE;
		cfg_if.wdata <= '0;
		req_if.valid <= 1'b0;
		req_if.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: nothing is assigned a level
		offer(make_req(lpic_pkg::MODE_EVENT, 5'd31, 1'b1, '1, 4'd0));
		offer(make_req(lpic_pkg::MODE_REEVAL, 5'd0, 1'b0, '0, 4'd15));
		idle_until_drained();

		program_controller(32'h0000FFFF, 32'h80000001, 3'd7,
			{32'h0000000C, 32'h00000003}, {32'h0000FF00, 32'h000000F0},
			{32'h0F000000, 32'h00FF0000}, 32'hF0000000);
		offer(make_req(lpic_pkg::MODE_EVENT, 5'd0, 1'b1, '0, 4'd0));
		offer(make_req(lpic_pkg::MODE_EVENT, 5'd0, 1'b0, '0, 4'd0));
		offer(make_req(lpic_pkg::MODE_EVENT, 5'd5, 1'b1, '1, 4'd3));
		offer(make_req(lpic_pkg::MODE_EVENT, 5'd16, 1'b1, 32'h00010000, 4'd4));
		offer(make_req(lpic_pkg::MODE_EVENT, 5'd5, 1'b0, '1, 4'd2));
		offer(make_req(lpic_pkg::MODE_EVENT, 5'd20, 1'b0, '1, 4'd0));
		offer(make_req(lpic_pkg::MODE_EVENT, 5'd31, 1'b1, '0, 4'd0));
		offer(make_req(lpic_pkg::MODE_EVENT, 5'd31, 1'b0, '0, 4'd15));
		offer(make_req(lpic_pkg::MODE_REEVAL, 5'd31, 1'b1, '1, 4'd7));
		offer(make_req(lpic_pkg::MODE_REEVAL, 5'd0, 1'b0, '0, 4'd6));
		idle_until_drained();

		// nmi priority zero: the current level floor drops to zero
		program_controller(32'h0, 32'h0, 3'd0, {32'h00000002, 32'h00000001},
			{32'h0, 32'h0}, {32'h0, 32'h0}, 32'h00010000);
		offer(make_req(lpic_pkg::MODE_EVENT, 5'd1, 1'b1, '1, 4'd15));
		offer(make_req(lpic_pkg::MODE_EVENT, 5'd16, 1'b1, '1, 4'd15));
		offer(make_req(lpic_pkg::MODE_REEVAL, 5'd0, 1'b0, 32'h00000002, 4'd9));
		idle_until_drained();

		program_controller('1, 32'h0, 3'd1, '1, '1, '1, '1);
		offer(make_req(lpic_pkg::MODE_EVENT, 5'd7, 1'b1, '1, 4'd15));
		offer(make_req(lpic_pkg::MODE_EVENT, 5'd7, 1'b0, '1, 4'd0));

		for (int b = 0; b < BLOCKS; b++) begin
			idle_until_drained();
			case (b)
				0: program_controller($urandom, $urandom, 3'($urandom_range(1, 7)),
					{sparse_lines(), sparse_lines()}, {sparse_lines(), sparse_lines()},
					{sparse_lines(), sparse_lines()}, sparse_lines());
				1: program_controller('1, '0, 3'd1, '1, '1, '1, '1);
				2: program_controller($urandom, $urandom, 3'd0,
					{sparse_lines(), sparse_lines()}, {sparse_lines(), sparse_lines()},
					{sparse_lines(), sparse_lines()}, sparse_lines());
				3: program_controller('0, '1, 3'd7,
					{sparse_lines(), sparse_lines()}, {sparse_lines(), sparse_lines()},
					{sparse_lines(), sparse_lines()}, sparse_lines());
				4: program_controller($urandom, sparse_lines(), 3'($urandom_range(0, 7)),
					{sparse_lines(), sparse_lines()}, {sparse_lines(), sparse_lines()},
					{sparse_lines(), sparse_lines()}, sparse_lines());
				default: program_controller($urandom, $urandom, 3'($urandom_range(1, 7)),
					{$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, $urandom);
			endcase
			if (b < 2) begin
				send_idle_pct <= 27;
				recv_idle_pct <= 72;
			end else if (b < 4) begin
				send_idle_pct <= 72;
				recv_idle_pct <= 27;
			end else begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
			end
			for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
				if (b == 4 && n == 20) begin
					hold_starts <= hold_starts + 1;
				end
				offer(random_req());
			end
		end
		idle_until_drained();

		if (fail_count == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lpic_pkg.sv
rtl/lpic_if.sv
rtl/level_priority_interrupt_controller_unit.sv
rtl/lpic_checker.sv
bench/lpic_outcome_monitor.sv
bench/level_priority_interrupt_controller_unit_test.sv
